@@ rtl/bmmd_pkg.sv @@
// Package for the banked memory map decoder.
// Holds the item types, command and region codes, and address map and reset constants.
// No dependencies.
package bmmd_pkg;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_PEEK  = 2'd2
  } cmd_e;

  typedef enum logic [3:0] {
    RG_RAM    = 4'd0,
    RG_BASIC  = 4'd1,
    RG_KERNAL = 4'd2,
    RG_CHAR   = 4'd3,
    RG_COLOR  = 4'd4,
    RG_VIDEO  = 4'd5,
    RG_SOUND  = 4'd6,
    RG_TIMER1 = 4'd7,
    RG_TIMER2 = 4'd8,
    RG_EXP    = 4'd9,
    RG_PORT   = 4'd10
  } region_e;

  localparam logic [15:0] BASIC_BASE  = 16'hA000;
  localparam logic [15:0] BASIC_LAST  = 16'hBFFF;
  localparam logic [15:0] IO_BASE     = 16'hD000;
  localparam logic [15:0] IO_LAST     = 16'hDFFF;
  localparam logic [15:0] VIDEO_LAST  = 16'hD3FF;
  localparam logic [15:0] SOUND_LAST  = 16'hD7FF;
  localparam logic [15:0] COLOR_BASE  = 16'hD800;
  localparam logic [15:0] COLOR_LAST  = 16'hDBFF;
  localparam logic [15:0] TIMER1_LAST = 16'hDCFF;
  localparam logic [15:0] TIMER2_LAST = 16'hDDFF;
  localparam logic [15:0] KERNAL_BASE = 16'hE000;
  localparam logic [15:0] PORT_LAST   = 16'h0001;

  localparam logic [15:0] VIDEO_MASK  = 16'h003F;
  localparam logic [15:0] SOUND_MASK  = 16'h001F;
  localparam logic [15:0] TIMER_MASK  = 16'h000F;
  localparam logic [15:0] EXP_MASK    = 16'h01FF;

  localparam logic [7:0] DIR_RESET   = 8'h2F;
  localparam logic [7:0] LATCH_RESET = 8'h37;
  localparam logic [7:0] LOW_NIBBLE  = 8'h0F;
  localparam logic [7:0] HIGH_NIBBLE = 8'hF0;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [7:0]  port_pins;
    logic [7:0]  external_data;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  region;
    logic [15:0] local_address;
    logic [7:0]  read_data;
    logic        external_read;
    logic        external_write;
  } out_item_t;

  typedef struct packed {
    logic       lbv_we;
    logic [7:0] lbv;
    logic       dir_we;
    logic       latch_we;
    logic       color_we;
    logic [7:0] wdata;
  } state_upd_t;

endpackage

@@ rtl/bmmd_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bmmd_ram #(
  parameter int Width = 4,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/bmmd_decode.sv @@
// Combinational resolution of one bus access: region, local address, data and strobes.
// Also produces the state updates the access causes. Depends on bmmd_pkg.
module bmmd_decode #(
  parameter int ColorDepth = 1024
) (
  input  bmmd_pkg::in_item_t          item_i,
  input  logic [7:0]                  dir_i,
  input  logic [7:0]                  latch_i,
  input  logic [7:0]                  lbv_i,
  input  logic [3:0]                  color_rd_i,
  output bmmd_pkg::out_item_t         res_o,
  output bmmd_pkg::state_upd_t        upd_o,
  output logic [$clog2(ColorDepth)-1:0] color_idx_o
);

  localparam int IdxW = $clog2(ColorDepth);

  logic [7:0]        pv;
  logic              lo, hi, ch;
  logic [15:0]       a;
  logic [15:0]       color_off;
  bmmd_pkg::region_e rg;
  bmmd_pkg::region_e rg_out;
  logic [15:0]       loc;
  logic [15:0]       loc_out;
  logic              is_write, is_read, is_dev;
  logic [7:0]        rd;
  logic              er, ew;

  assign a         = item_i.address;
  assign pv        = (latch_i & dir_i) | (item_i.port_pins & ~dir_i);
  assign lo        = pv[0];
  assign hi        = pv[1];
  assign ch        = pv[2];
  assign color_off = a - bmmd_pkg::COLOR_BASE;
  assign color_idx_o = color_off[IdxW-1:0];
  assign is_write  = (item_i.command == bmmd_pkg::CMD_WRITE);
  assign is_read   = (item_i.command == bmmd_pkg::CMD_READ);

  always_comb begin
    rg = bmmd_pkg::RG_RAM;
    if (a <= bmmd_pkg::PORT_LAST) begin
      rg = bmmd_pkg::RG_PORT;
    end else if (a inside {[bmmd_pkg::BASIC_BASE:bmmd_pkg::BASIC_LAST]}) begin
      rg = (lo && hi) ? bmmd_pkg::RG_BASIC : bmmd_pkg::RG_RAM;
    end else if (a inside {[bmmd_pkg::IO_BASE:bmmd_pkg::IO_LAST]}) begin
      if (!lo && !hi) begin
        rg = bmmd_pkg::RG_RAM;
      end else if (!ch) begin
        rg = bmmd_pkg::RG_CHAR;
      end else if (a <= bmmd_pkg::VIDEO_LAST) begin
        rg = bmmd_pkg::RG_VIDEO;
      end else if (a <= bmmd_pkg::SOUND_LAST) begin
        rg = bmmd_pkg::RG_SOUND;
      end else if (a <= bmmd_pkg::COLOR_LAST) begin
        rg = bmmd_pkg::RG_COLOR;
      end else if (a <= bmmd_pkg::TIMER1_LAST) begin
        rg = bmmd_pkg::RG_TIMER1;
      end else if (a <= bmmd_pkg::TIMER2_LAST) begin
        rg = bmmd_pkg::RG_TIMER2;
      end else begin
        rg = bmmd_pkg::RG_EXP;
      end
    end else if (a >= bmmd_pkg::KERNAL_BASE) begin
      rg = hi ? bmmd_pkg::RG_KERNAL : bmmd_pkg::RG_RAM;
    end
  end

  always_comb begin
    case (rg)
      bmmd_pkg::RG_BASIC:  loc = a - bmmd_pkg::BASIC_BASE;
      bmmd_pkg::RG_KERNAL: loc = a - bmmd_pkg::KERNAL_BASE;
      bmmd_pkg::RG_CHAR:   loc = a - bmmd_pkg::IO_BASE;
      bmmd_pkg::RG_COLOR:  loc = 16'(color_off[IdxW-1:0]);
      bmmd_pkg::RG_VIDEO:  loc = a & bmmd_pkg::VIDEO_MASK;
      bmmd_pkg::RG_SOUND:  loc = a & bmmd_pkg::SOUND_MASK;
      bmmd_pkg::RG_TIMER1,
      bmmd_pkg::RG_TIMER2: loc = a & bmmd_pkg::TIMER_MASK;
      bmmd_pkg::RG_EXP:    loc = a & bmmd_pkg::EXP_MASK;
      default:             loc = a;
    endcase
  end

  assign is_dev = (rg inside {bmmd_pkg::RG_VIDEO, bmmd_pkg::RG_SOUND,
                              bmmd_pkg::RG_TIMER1, bmmd_pkg::RG_TIMER2});

  always_comb begin
    rg_out = rg;
    loc_out = loc;
    rd = 8'h00;
    er = 1'b0;
    ew = 1'b0;
    upd_o = '0;
    upd_o.wdata = item_i.write_data;
    if (is_write) begin
      upd_o.lbv_we = 1'b1;
      upd_o.lbv    = item_i.write_data;
      case (rg)
        bmmd_pkg::RG_PORT: begin
          upd_o.dir_we   = (a == 16'h0000);
          upd_o.latch_we = (a != 16'h0000);
        end
        bmmd_pkg::RG_COLOR: begin
          upd_o.color_we = 1'b1;
        end
        bmmd_pkg::RG_EXP: begin
          ew = 1'b0;
        end
        default: begin
          ew = 1'b1;
          if (!is_dev) begin
            rg_out  = bmmd_pkg::RG_RAM;
            loc_out = a;
          end
        end
      endcase
    end else begin
      case (rg)
        bmmd_pkg::RG_PORT: begin
          rd = (a == 16'h0000) ? dir_i : pv;
        end
        bmmd_pkg::RG_COLOR: begin
          rd = (lbv_i & bmmd_pkg::HIGH_NIBBLE) | {4'h0, color_rd_i};
        end
        bmmd_pkg::RG_EXP: begin
          rd = lbv_i;
        end
        default: begin
          if (is_dev && !is_read) begin
            rd = lbv_i;
          end else begin
            rd = item_i.external_data;
            er = is_read;
          end
        end
      endcase
      upd_o.lbv_we = is_read;
      upd_o.lbv    = rd;
    end
  end

  assign res_o.region         = rg_out;
  assign res_o.local_address  = loc_out;
  assign res_o.read_data      = rd;
  assign res_o.external_read  = er;
  assign res_o.external_write = ew;

endmodule

@@ rtl/banked_memory_map_decoder_core.sv @@
// Top level of the banked memory map decoder: input register, decode, result register.
// Depends on bmmd_pkg, bmmd_decode and bmmd_ram.
//
// Usage: each input item is one bus access (read, write or peek) with the current
// port pin levels and the byte that external RAM, ROM or device returns for it.
// Each item yields exactly one result item with region, local address, read data
// and the external read and write strobes. Items are accepted when in_valid_i is
// high and in_stall_o is low; results leave when out_valid_o is high and
// out_stall_i is low. A result passes through the input register and the result
// register after its item is accepted. One item is accepted every cycle while the
// output is taken and the color store is not being cleared.
// The color store read is issued as the item is accepted and its data is ready
// in the decode cycle; a color write by the item ahead is bypassed.
// After reset the block clears the 1024-entry color store, one entry per cycle,
// holding in_stall_o high until the clear is done. The port direction resets to
// 0x2F, the port latch to 0x37 and the last bus value to zero.
// When the receiver stalls, the result register holds; the item behind it waits
// in the input register and in_stall_o rises until the result moves on.
module banked_memory_map_decoder_core #(
  parameter int COLOR_DEPTH = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bmmd_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bmmd_pkg::out_item_t out_item_o
);

  localparam int IdxW = $clog2(COLOR_DEPTH);

  logic                 clear_q, clear_d;
  logic [IdxW-1:0]      clr_idx_q, clr_idx_d;
  logic                 s1_valid_q, s1_valid_d;
  bmmd_pkg::in_item_t   s1_item_q;
  logic                 out_valid_q, out_valid_d;
  bmmd_pkg::out_item_t  out_item_q;
  logic [7:0]           dir_q, latch_q, lbv_q;
  logic                 fwd_q, fwd_d;
  logic [3:0]           fwd_data_q;

  logic                 in_accept;
  logic                 s1_fire;
  bmmd_pkg::out_item_t  res;
  bmmd_pkg::state_upd_t upd;
  logic [IdxW-1:0]      color_idx;
  logic [IdxW-1:0]      rd_idx;
  logic [15:0]          rd_off;
  logic [3:0]           ram_rdata;
  logic [3:0]           color_rd;
  logic                 ram_we;
  logic [IdxW-1:0]      ram_waddr;
  logic [3:0]           ram_wdata;
  logic                 color_wr;

  assign s1_fire    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = clear_q || (s1_valid_q && !s1_fire);
  assign in_accept  = in_valid_i && !in_stall_o;

  assign rd_off   = in_item_i.address - bmmd_pkg::COLOR_BASE;
  assign rd_idx   = rd_off[IdxW-1:0];
  assign color_wr = s1_fire && upd.color_we;

  assign ram_we    = clear_q || color_wr;
  assign ram_waddr = clear_q ? clr_idx_q : color_idx;
  assign ram_wdata = clear_q ? 4'h0 : upd.wdata[3:0];

  bmmd_ram #(
    .Width(4),
    .Depth(COLOR_DEPTH)
  ) u_color_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_accept),
    .raddr_i (rd_idx),
    .rdata_o (ram_rdata)
  );

  assign color_rd = fwd_q ? fwd_data_q : ram_rdata;

  bmmd_decode #(
    .ColorDepth(COLOR_DEPTH)
  ) u_decode (
    .item_i      (s1_item_q),
    .dir_i       (dir_q),
    .latch_i     (latch_q),
    .lbv_i       (lbv_q),
    .color_rd_i  (color_rd),
    .res_o       (res),
    .upd_o       (upd),
    .color_idx_o (color_idx)
  );

  always_comb begin
    clear_d   = clear_q;
    clr_idx_d = clr_idx_q;
    if (clear_q) begin
      clr_idx_d = clr_idx_q + 1'b1;
      if (clr_idx_q == IdxW'(COLOR_DEPTH - 1)) begin
        clear_d = 1'b0;
      end
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
    fwd_d = fwd_q;
    if (in_accept) begin
      fwd_d = color_wr && (color_idx == rd_idx);
    end else if (s1_fire) begin
      fwd_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_q     <= 1'b1;
      clr_idx_q   <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      fwd_q       <= 1'b0;
      dir_q       <= bmmd_pkg::DIR_RESET;
      latch_q     <= bmmd_pkg::LATCH_RESET;
      lbv_q       <= 8'h00;
    end else begin
      clear_q     <= clear_d;
      clr_idx_q   <= clr_idx_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      fwd_q       <= fwd_d;
      if (s1_fire) begin
        if (upd.dir_we) begin
          dir_q <= upd.wdata;
        end
        if (upd.latch_we) begin
          latch_q <= upd.wdata;
        end
        if (upd.lbv_we) begin
          lbv_q <= upd.lbv;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q  <= in_item_i;
      fwd_data_q <= upd.wdata[3:0];
    end
    if (s1_fire) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // No item may be in flight while the color store is being cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_q |-> !(s1_valid_q || out_valid_q))
    else $error("item in flight during color store clear");

  // The color bypass is only armed for an item sitting in the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> s1_valid_q)
    else $error("color bypass armed without an item");

  // A result never raises both external strobes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_item_q.external_read && out_item_q.external_write))
    else $error("both external strobes set");

  // The input register advances whenever the result register is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_valid_q) |=> out_valid_q)
    else $error("decode stage stalled with a free result register");

endmodule

@@ tb/banked_memory_map_decoder_core_tb.sv @@
// Self-checking testbench for banked_memory_map_decoder_core.
// Predicts every bus access from its own copy of the port registers, bus value and color store.
// Depends on bmmd_pkg and the core; drives both channels with random gaps and stalls.
module banked_memory_map_decoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bmmd_pkg::*;

  localparam int          CLK_PERIOD     = 4;
  localparam int          RESET_CYCLES   = 11;
  localparam int          COLOR_DEPTH    = 1024;
  localparam logic [15:0] COLOR_MASK     = 16'(COLOR_DEPTH - 1);
  localparam int          RANDOM_ITEMS   = 570;
  localparam int          WATCHDOG_LIMIT = 5000;
  localparam int          DRAIN_CYCLES   = 20;
  localparam int          PRINT_LIMIT    = 40;
  localparam logic [1:0]  CMD_UNUSED     = 2'd3;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  in_item_t  in_item_i   = '0;
  logic      out_stall_i = 1'b0;
  logic      in_stall_o;
  logic      out_valid_o;
  out_item_t out_item_o;

  banked_memory_map_decoder_core #(
    .COLOR_DEPTH(COLOR_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  in_item_t  access_queue[$];
  out_item_t decoded_queue[$];

  logic [7:0] port_dir_q;
  logic [7:0] port_latch_q;
  logic [7:0] bus_value_q;
  logic [3:0] color_mem[COLOR_DEPTH];

  int          mismatch_count = 0;
  int          idle_cycles    = 0;
  int          cmd_count[4];
  logic [10:0] regions_hit    = '0;
  int          tx_gap         = 0;
  int          tx_calm        = 0;
  int          rx_hold        = 0;
  int          rx_calm        = 0;

  function automatic out_item_t decode_access(in_item_t it);
    out_item_t   res;
    logic [7:0]  pv;
    logic [15:0] a;
    logic [15:0] loc;
    logic [7:0]  rd;
    logic        er;
    logic        ew;
    logic        is_read;
    logic        is_dev;
    region_e     rg;
    a  = it.address;
    pv = (port_latch_q & port_dir_q) | (it.port_pins & ~port_dir_q);
    if (a <= PORT_LAST) begin
      rg = RG_PORT;
    end else if (a >= BASIC_BASE && a <= BASIC_LAST) begin
      rg = (pv[0] && pv[1]) ? RG_BASIC : RG_RAM;
    end else if (a >= IO_BASE && a <= IO_LAST) begin
      if (!pv[0] && !pv[1]) rg = RG_RAM;
      else if (!pv[2]) rg = RG_CHAR;
      else if (a <= VIDEO_LAST) rg = RG_VIDEO;
      else if (a <= SOUND_LAST) rg = RG_SOUND;
      else if (a <= COLOR_LAST) rg = RG_COLOR;
      else if (a <= TIMER1_LAST) rg = RG_TIMER1;
      else if (a <= TIMER2_LAST) rg = RG_TIMER2;
      else rg = RG_EXP;
    end else if (a >= KERNAL_BASE) begin
      rg = pv[1] ? RG_KERNAL : RG_RAM;
    end else begin
      rg = RG_RAM;
    end
    case (rg)
      RG_BASIC:             loc = a - BASIC_BASE;
      RG_KERNAL:            loc = a - KERNAL_BASE;
      RG_CHAR:              loc = a - IO_BASE;
      RG_COLOR:             loc = (a - COLOR_BASE) & COLOR_MASK;
      RG_VIDEO:             loc = a & VIDEO_MASK;
      RG_SOUND:             loc = a & SOUND_MASK;
      RG_TIMER1, RG_TIMER2: loc = a & TIMER_MASK;
      RG_EXP:               loc = a & EXP_MASK;
      default:              loc = a;
    endcase
    rd      = '0;
    er      = 1'b0;
    ew      = 1'b0;
    is_read = (it.command == CMD_READ);
    is_dev  = (rg >= RG_VIDEO && rg <= RG_TIMER2);
    if (it.command == CMD_WRITE) begin
      bus_value_q = it.write_data;
      if (rg == RG_PORT) begin
        if (a[0]) port_latch_q = it.write_data;
        else port_dir_q = it.write_data;
      end else if (rg == RG_COLOR) begin
        color_mem[loc[9:0]] = it.write_data[3:0];
      end else if (is_dev) begin
        ew = 1'b1;
      end else if (rg != RG_EXP) begin
        rg  = RG_RAM;
        loc = a;
        ew  = 1'b1;
      end
    end else begin
      case (rg)
        RG_PORT:  rd = a[0] ? pv : port_dir_q;
        RG_COLOR: rd = {bus_value_q[7:4], color_mem[loc[9:0]]};
        RG_EXP:   rd = bus_value_q;
        default: begin
          if (is_dev && !is_read) begin
            rd = bus_value_q;
          end else begin
            rd = it.external_data;
            er = is_read;
          end
        end
      endcase
      if (is_read) bus_value_q = rd;
    end
    res.region         = rg;
    res.local_address  = loc;
    res.read_data      = rd;
    res.external_read  = er;
    res.external_write = ew;
    return res;
  endfunction

  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) begin
      calm_left = $urandom_range(15, 40);
      return 0;
    end
    return $urandom_range(0, 5);
  endfunction

  function automatic logic [15:0] pick_address();
    logic [15:0] edges[22];
    edges = '{16'h0000, 16'h0001, 16'h0002, 16'h9FFF, 16'hA000, 16'hBFFF, 16'hC000,
              16'hCFFF, 16'hD000, 16'hD3FF, 16'hD400, 16'hD7FF, 16'hD800, 16'hDBFF,
              16'hDC00, 16'hDCFF, 16'hDD00, 16'hDDFF, 16'hDE00, 16'hDFFF, 16'hE000,
              16'hFFFF};
    case ($urandom_range(0, 7))
      0:       return 16'($urandom_range(0, 1));
      1:       return BASIC_BASE + 16'($urandom_range(0, 16'h1FFF));
      2, 3:    return IO_BASE + 16'($urandom_range(0, 16'h0FFF));
      4:       return KERNAL_BASE + 16'($urandom_range(0, 16'h1FFF));
      5:       return 16'($urandom_range(0, 16'hFFFF));
      6:       return edges[$urandom_range(0, 21)];
      default: return COLOR_BASE + 16'($urandom_range(0, COLOR_DEPTH - 1));
    endcase
  endfunction

  task automatic queue_access(input logic [1:0] cmd, input logic [15:0] addr,
                              input logic [7:0] wdata, input logic [7:0] pins,
                              input logic [7:0] ext);
    in_item_t it;
    it.command       = cmd;
    it.address       = addr;
    it.write_data    = wdata;
    it.port_pins     = pins;
    it.external_data = ext;
    access_queue.push_back(it);
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_LIMIT) $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i  <= '0;
      tx_gap     <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        decoded_queue.push_back(decode_access(in_item_i));
        cmd_count[in_item_i.command]++;
        regions_hit[decoded_queue[$].region] = 1'b1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (tx_gap > 0) begin
          in_valid_i <= 1'b0;
          tx_gap     <= tx_gap - 1;
        end else if (access_queue.size() > 0) begin
          in_item_i  <= access_queue.pop_front();
          in_valid_i <= 1'b1;
          tx_gap     <= draw_wait(tx_calm);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (decoded_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected result %p", out_item_o));
        end else begin
          want = decoded_queue.pop_front();
          if (out_item_o.region != want.region)
            report_mismatch($sformatf("region %0d, want %0d", out_item_o.region, want.region));
          if (out_item_o.local_address != want.local_address)
            report_mismatch($sformatf("local_address %h, want %h",
                                      out_item_o.local_address, want.local_address));
          if (out_item_o.read_data != want.read_data)
            report_mismatch($sformatf("read_data %h, want %h",
                                      out_item_o.read_data, want.read_data));
          if (out_item_o.external_read != want.external_read)
            report_mismatch($sformatf("external_read %b, want %b",
                                      out_item_o.external_read, want.external_read));
          if (out_item_o.external_write != want.external_write)
            report_mismatch($sformatf("external_write %b, want %b",
                                      out_item_o.external_write, want.external_write));
        end
        rx_hold = draw_wait(rx_calm);
      end else if (out_valid_o && rx_hold > 0) begin
        rx_hold--;
      end
      out_stall_i <= (rx_hold > 0);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    logic [15:0] addr;
    int          sel;
    port_dir_q   = DIR_RESET;
    port_latch_q = LATCH_RESET;
    bus_value_q  = '0;
    foreach (color_mem[i]) color_mem[i] = '0;
    foreach (cmd_count[i]) cmd_count[i] = 0;

    queue_access(CMD_READ,   16'h0000, 8'h00, 8'h00, 8'h00);
    queue_access(CMD_READ,   16'h0001, 8'hFF, 8'h00, 8'hFF);
    queue_access(CMD_PEEK,   16'h0001, 8'h00, 8'hFF, 8'h00);
    queue_access(CMD_READ,   16'hA000, 8'h00, 8'hFF, 8'hFF);
    queue_access(CMD_READ,   16'hBFFF, 8'h00, 8'h00, 8'h5A);
    queue_access(CMD_PEEK,   16'hFFFF, 8'h00, 8'hFF, 8'hA5);
    queue_access(CMD_READ,   16'hD3FF, 8'h00, 8'h00, 8'h81);
    queue_access(CMD_PEEK,   16'hD400, 8'h00, 8'h00, 8'h42);
    queue_access(CMD_WRITE,  16'hD800, 8'hFF, 8'h00, 8'h00);
    queue_access(CMD_READ,   16'hD800, 8'h00, 8'hFF, 8'h00);
    queue_access(CMD_READ,   16'hDBFF, 8'h00, 8'h00, 8'h00);
    queue_access(CMD_READ,   16'hDC00, 8'h00, 8'h00, 8'h3C);
    queue_access(CMD_WRITE,  16'hDDFF, 8'h96, 8'h00, 8'h00);
    queue_access(CMD_READ,   16'hDE00, 8'h00, 8'h00, 8'hEE);
    queue_access(CMD_WRITE,  16'hDFFF, 8'h11, 8'h00, 8'h00);
    queue_access(CMD_WRITE,  16'hA000, 8'h77, 8'h00, 8'h00);
    queue_access(CMD_WRITE,  16'hE000, 8'h88, 8'h00, 8'h00);
    queue_access(CMD_UNUSED, 16'hD020, 8'hFF, 8'hFF, 8'hFF);
    queue_access(CMD_WRITE,  16'h0000, 8'h00, 8'h00, 8'h00);
    queue_access(CMD_READ,   16'hD000, 8'h00, 8'h03, 8'h24);
    queue_access(CMD_READ,   16'hE000, 8'h00, 8'h00, 8'h99);
    queue_access(CMD_WRITE,  16'h0000, 8'hFF, 8'h00, 8'h00);
    queue_access(CMD_WRITE,  16'h0001, 8'h00, 8'hFF, 8'h00);
    queue_access(CMD_READ,   16'h0001, 8'h00, 8'hFF, 8'h00);
    queue_access(CMD_WRITE,  16'h0001, 8'hFF, 8'h00, 8'h00);
    queue_access(CMD_WRITE,  16'h0000, DIR_RESET, 8'h00, 8'h00);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 6) begin
        queue_access(CMD_WRITE, 16'($urandom_range(0, 1)), rand_byte(), rand_byte(),
                     rand_byte());
      end else if (sel < 12) begin
        queue_access(2'($urandom_range(0, 3)), 16'($urandom_range(0, 16'hFFFF)),
                     rand_byte(), rand_byte(), rand_byte());
      end else if (sel < 30) begin
        // Reuse a few color entries so reads see earlier writes.
        addr = COLOR_BASE + 16'($urandom_range(0, 15) * 64 + $urandom_range(0, 1));
        queue_access(CMD_WRITE, addr, rand_byte(), rand_byte(), rand_byte());
        queue_access(2'($urandom_range(0, 3)), addr, rand_byte(), rand_byte(), rand_byte());
      end else begin
        sel = $urandom_range(0, 9);
        queue_access((sel < 4) ? CMD_READ : (sel < 7) ? CMD_WRITE : (sel < 9) ? CMD_PEEK
                     : CMD_UNUSED, pick_address(), rand_byte(), rand_byte(), rand_byte());
      end
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while ((access_queue.size() != 0 || in_valid_i || decoded_queue.size() != 0) &&
           idle_cycles < WATCHDOG_LIMIT)
      @(negedge clk_i);

    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout after %0d cycles with no item moving.", idle_cycles);
      $display("FAIL");
    end else begin
      repeat (DRAIN_CYCLES) @(negedge clk_i);
      if (decoded_queue.size() != 0)
        report_mismatch($sformatf("%0d results never arrived", decoded_queue.size()));
      $display("Checked %0d accesses: %0d reads, %0d writes, %0d peeks, %0d unused code.",
               cmd_count[0] + cmd_count[1] + cmd_count[2] + cmd_count[3],
               cmd_count[0], cmd_count[1], cmd_count[2], cmd_count[3]);
      $display("Regions decoded: %0d of 11; mismatches: %0d.", $countones(regions_hit),
               mismatch_count);
      if (mismatch_count == 0) begin
        $display("PASS");
      end else begin
        $display("FAIL");
      end
    end
    $finish;
  end

endmodule
